// File: rtl/bsot_pkg.sv
// ----------------------------------------------------------------------------
// bsot_pkg
// Shared types and constants for the box/sphere overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package bsot_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int AXIS_WIDTH  = 16;
    localparam int AXIS_FRAC   = 14;
    localparam int REG_WIDTH   = 3 * COORD_WIDTH;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;

    // squared length and its root
    localparam int SUM_WIDTH   = 34;
    localparam int ROOT_WIDTH  = SUM_WIDTH / 2;

    localparam int CFG_IDX_WIDTH = 3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_CENTER   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_HALF_EXTENTS = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_AXIS_ONE     = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_AXIS_TWO     = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_AXIS_THREE   = 3'd4;

    localparam logic [COORD_WIDTH-1:0] OUT_MAX = '1;

    // data that rides alongside the square root
    typedef struct packed {
        logic                 big;
        logic [RAD_WIDTH-1:0] radius;
    } side_t;

endpackage

`default_nettype wire

// File: rtl/box_sphere_overlap_test.sv
// ----------------------------------------------------------------------------
// box_sphere_overlap_test
// Tests spheres against an oriented box held in configuration registers.
// ----------------------------------------------------------------------------
// One sphere is accepted per cycle and one result leaves per cycle. The
// pipeline holds eight arithmetic stages (offset, projection products, sums,
// axis excess, excess products, rounding, squares, sum of squares), six
// square-root stages at three root bits each (two in the last), and the
// output register. The whole pipeline advances together, so it stalls only
// while a result sits in the output register untaken. Box registers are to be
// written through the cfg port while the pipeline is empty; this is unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module box_sphere_overlap_test (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [bsot_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  wire logic [bsot_pkg::REG_WIDTH-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [bsot_pkg::COORD_WIDTH-1:0] sphere_x,
    input  wire logic signed [bsot_pkg::COORD_WIDTH-1:0] sphere_y,
    input  wire logic signed [bsot_pkg::COORD_WIDTH-1:0] sphere_z,
    input  wire logic [bsot_pkg::RAD_WIDTH-1:0]       sphere_radius,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      hit,
    output logic [bsot_pkg::COORD_WIDTH-1:0]          excess_distance
);

    localparam int CW = bsot_pkg::COORD_WIDTH;
    localparam int AW = bsot_pkg::AXIS_WIDTH;
    localparam int AF = bsot_pkg::AXIS_FRAC;
    localparam int DW = CW + 1;            // offset
    localparam int PW = DW + AW;           // one projection product
    localparam int SW = PW + 2;            // projection sum
    localparam int XW = SW + 2;            // h*2^14 - |p|
    localparam int EW = XW - AF;           // rounded axis excess
    localparam int QW = EW + AW;           // excess product
    localparam int CWA = QW + 2;           // component accumulator
    localparam int MW = CW;                // component magnitude
    localparam int SQ = 2 * MW;
    localparam int SUMW = bsot_pkg::SUM_WIDTH;
    localparam int RTW = bsot_pkg::ROOT_WIDTH;
    localparam int RDW = bsot_pkg::RAD_WIDTH;

    // ------------------------------------------------------------------
    // configuration
    logic [bsot_pkg::REG_WIDTH-1:0] center_reg;
    logic [bsot_pkg::REG_WIDTH-1:0] half_reg;
    logic [bsot_pkg::REG_WIDTH-1:0] axis_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= '0;
            half_reg    <= '0;
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bsot_pkg::REG_BOX_CENTER:   center_reg  <= cfg_data;
                bsot_pkg::REG_HALF_EXTENTS: half_reg    <= cfg_data;
                bsot_pkg::REG_AXIS_ONE:     axis_reg[0] <= cfg_data;
                bsot_pkg::REG_AXIS_TWO:     axis_reg[1] <= cfg_data;
                bsot_pkg::REG_AXIS_THREE:   axis_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [CW-1:0] ctr  [3];
    logic signed [CW-1:0] half [3];
    logic signed [AW-1:0] ax   [3][3];   // [axis][component]

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ctr[k]  = $signed(center_reg[k*CW +: CW]);
            half[k] = $signed(half_reg[k*CW +: CW]);
            for (int i = 0; i < 3; i++)
            begin
                ax[i][k] = $signed(axis_reg[i][k*AW +: AW]);
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: everything moves when the output slot frees up
    logic advance;
    logic out_valid_reg;
    logic sq_vld;
    logic [RTW-1:0] sq_root;
    bsot_pkg::side_t sq_side;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic [RDW-1:0] rad1_reg, rad2_reg, rad3_reg, rad4_reg, rad5_reg, rad6_reg, rad7_reg;
    logic big7_reg;
    bsot_pkg::side_t side8_reg;

    logic signed [DW-1:0]  d_reg   [3];
    logic signed [PW-1:0]  prod_reg [3][3];
    logic signed [SW-1:0]  p_reg   [3];
    logic signed [EW-1:0]  e_reg   [3];
    logic signed [QW-1:0]  q_reg   [3][3];
    logic [MW-1:0]         mag_reg [3];
    logic big6_reg;
    logic [SQ-1:0]         sqr_reg [3];
    logic [SUMW-1:0]       sum_reg;

    logic signed [DW-1:0]  d_next   [3];
    logic signed [PW-1:0]  prod_next [3][3];
    logic signed [SW-1:0]  p_next   [3];
    logic signed [EW-1:0]  e_next   [3];
    logic signed [QW-1:0]  q_next   [3][3];
    logic [MW-1:0]         mag_next [3];
    logic                  big6_next;
    logic [SQ-1:0]         sqr_next [3];
    logic [SUMW-1:0]       sum_next;

    logic signed [CW-1:0] sph [3];
    assign sph[0] = sphere_x;
    assign sph[1] = sphere_y;
    assign sph[2] = sphere_z;

    always_comb
    begin
        logic signed [SW-1:0]  ap;
        logic signed [XW-1:0]  diff;
        logic signed [CWA-1:0] acc;
        logic signed [CWA-AF-1:0] comp;
        logic signed [CWA-AF-1:0] cmag;
        big6_next = 1'b0;
        sum_next  = '0;
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = DW'(sph[k]) - DW'(ctr[k]);
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[i][k] = PW'(d_reg[k]) * PW'(ax[i][k]);
                q_next[i][k]    = QW'(e_reg[i]) * QW'(ax[i][k]);
            end
            p_next[i] = SW'(prod_reg[i][0]) + SW'(prod_reg[i][1]) + SW'(prod_reg[i][2]);

            ap   = p_reg[i][SW-1] ? -p_reg[i] : p_reg[i];
            diff = (XW'(half[i]) <<< AF) - XW'(ap);
            // axis skipped or sphere centre inside this slab
            if (half[i] <= 0 || diff >= 0)
            begin
                e_next[i] = '0;
            end
            else
            begin
                e_next[i] = EW'((diff + XW'(1 <<< (AF - 1))) >>> AF);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            acc  = CWA'(q_reg[0][k]) + CWA'(q_reg[1][k]) + CWA'(q_reg[2][k]);
            comp = (CWA-AF)'((acc + CWA'(1 <<< (AF - 1))) >>> AF);
            cmag = comp[CWA-AF-1] ? -comp : comp;
            if (cmag[CWA-AF-1:MW] != '0)
            begin
                big6_next = 1'b1;
            end
            mag_next[k] = cmag[MW-1:0];
            sqr_next[k] = SQ'(mag_reg[k]) * SQ'(mag_reg[k]);
            sum_next    = sum_next + SUMW'(sqr_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_reg    <= d_next;
            prod_reg <= prod_next;
            p_reg    <= p_next;
            e_reg    <= e_next;
            q_reg    <= q_next;
            mag_reg  <= mag_next;
            big6_reg <= big6_next;
            sqr_reg  <= sqr_next;
            big7_reg <= big6_reg;
            sum_reg  <= sum_next;
            rad1_reg <= sphere_radius;
            rad2_reg <= rad1_reg;
            rad3_reg <= rad2_reg;
            rad4_reg <= rad3_reg;
            rad5_reg <= rad4_reg;
            rad6_reg <= rad5_reg;
            rad7_reg <= rad6_reg;
            side8_reg.big    <= big7_reg;
            side8_reg.radius <= rad7_reg;
        end
    end

    bsot_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (v8_reg),
        .in_num   (sum_reg),
        .in_side  (side8_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // ------------------------------------------------------------------
    // output register
    logic                 hit_reg;
    logic [CW-1:0]        excess_reg;
    logic                 hit_next;
    logic [CW-1:0]        excess_next;

    always_comb
    begin
        hit_next    = !sq_side.big && (sq_root < RTW'(sq_side.radius));
        if (sq_side.big || sq_root[RTW-1:CW] != '0)
        begin
            excess_next = bsot_pkg::OUT_MAX;
        end
        else
        begin
            excess_next = sq_root[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg    <= hit_next;
            excess_reg <= excess_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign excess_distance = excess_reg;

    // ------------------------------------------------------------------
    ap_ready_follows_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid_reg || out_ready))
        else $error("in_ready does not track output slot");

    ap_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted transaction missing from first stage");

    ap_hit_not_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> (excess_reg != bsot_pkg::OUT_MAX))
        else $error("hit with saturated distance");

    ap_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(v8_reg) && $stable(sum_reg)))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// File: rtl/bsot_sqrt.sv
// ----------------------------------------------------------------------------
// bsot_sqrt
// Pipelined integer square root, floor(sqrt(n)), three result bits per stage (two in the last).
// ----------------------------------------------------------------------------
`default_nettype none

module bsot_sqrt (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_vld,
    input  wire logic [bsot_pkg::SUM_WIDTH-1:0]    in_num,
    input  wire bsot_pkg::side_t                   in_side,
    output logic                                   out_vld,
    output logic [bsot_pkg::ROOT_WIDTH-1:0]        out_root,
    output bsot_pkg::side_t                        out_side
);

    localparam int ITERS  = bsot_pkg::ROOT_WIDTH;
    localparam int PER    = 3;
    localparam int STAGES = (ITERS + PER - 1) / PER;
    localparam int NW     = bsot_pkg::SUM_WIDTH;
    localparam int RW     = bsot_pkg::ROOT_WIDTH;
    localparam int REM_W  = RW + 3;

    logic                     vld_reg  [STAGES];
    logic [REM_W-1:0]         rem_reg  [STAGES];
    logic [RW-1:0]            root_reg [STAGES];
    logic [NW-1:0]            num_reg  [STAGES];
    bsot_pkg::side_t          side_reg [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic             vld_in;
            logic [REM_W-1:0] rem_in;
            logic [RW-1:0]    root_in;
            logic [NW-1:0]    num_in;
            bsot_pkg::side_t  side_in;
            logic [REM_W-1:0] rem_next;
            logic [RW-1:0]    root_next;
            logic [NW-1:0]    num_next;

            if (s == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign rem_in  = '0;
                assign root_in = '0;
                assign num_in  = in_num;
                assign side_in = in_side;
            end
            else
            begin : g_rest
                assign vld_in  = vld_reg[s-1];
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
                assign num_in  = num_reg[s-1];
                assign side_in = side_reg[s-1];
            end

            always_comb
            begin
                logic [REM_W-1:0] r;
                logic [REM_W-1:0] t;
                r         = rem_in;
                t         = '0;
                root_next = root_in;
                num_next  = num_in;
                for (int j = 0; j < PER; j++)
                begin
                    if (s * PER + j < ITERS)
                    begin
                        // bring down the next bit pair; trial is 4*root + 1
                        r = {r[REM_W-3:0], num_next[NW-1 -: 2]};
                        t = REM_W'({root_next, 2'b01});
                        num_next = {num_next[NW-3:0], 2'b00};
                        if (r >= t)
                        begin
                            r         = r - t;
                            root_next = {root_next[RW-2:0], 1'b1};
                        end
                        else
                        begin
                            root_next = {root_next[RW-2:0], 1'b0};
                        end
                    end
                end
                rem_next = r;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                    num_reg[s]  <= num_next;
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[STAGES-1];
    assign out_root = root_reg[STAGES-1];
    assign out_side = side_reg[STAGES-1];

endmodule

`default_nettype wire

// File: sim/box_sphere_overlap_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_sphere_overlap_test_tb
// Self-checking bench for the sphere versus oriented box overlap test. A
// short table of directed spheres runs first, then random spheres against
// several box settings, the first four with random backpressure on both sides.
// Results are checked in order against table values or an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module box_sphere_overlap_test_tb;

    localparam logic [bsot_pkg::CFG_IDX_WIDTH-1:0] REG_NONE = 3'd7;   // unmapped index
    localparam int NUM_REGS   = 5;
    localparam int RAND_SETS  = 6;
    localparam int SET_ITEMS  = 215;
    localparam int DRAIN_WAIT = 20;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [15:0] Q_ONE = 16'd16384;   // 1.0 in Q1.14
    localparam logic [15:0] Q_NEG = 16'hC000;    // -1.0 in Q1.14
    localparam logic [15:0] Q_RT2 = 16'd11585;   // ~0.7071 in Q1.14

    typedef struct {
        logic signed [bsot_pkg::COORD_WIDTH-1:0] x, y, z;
        logic [bsot_pkg::RAD_WIDTH-1:0]          r;
    } sphere_t;

    typedef struct {
        logic                             hit;
        logic [bsot_pkg::COORD_WIDTH-1:0] distance;
    } verdict_t;

    typedef struct {
        int          box;
        sphere_t     s;
        bit          typed;
        logic        ehit;
        logic [15:0] edist;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [bsot_pkg::CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [bsot_pkg::REG_WIDTH-1:0] cfg_data = '0;
    logic cfg_ready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [bsot_pkg::COORD_WIDTH-1:0] sphere_x = '0, sphere_y = '0, sphere_z = '0;
    logic [bsot_pkg::RAD_WIDTH-1:0] sphere_radius = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic [bsot_pkg::COORD_WIDTH-1:0] excess_distance;

    logic [bsot_pkg::REG_WIDTH-1:0] box_regs [NUM_REGS];   // mirror of the box registers
    verdict_t expected_q [$];
    int tx_idle = 0, rx_idle = 0;
    int errors = 0, checked = 0, hits_seen = 0, sat_seen = 0, cycles = 0;

    box_sphere_overlap_test u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .sphere_x(sphere_x), .sphere_y(sphere_y), .sphere_z(sphere_z),
        .sphere_radius(sphere_radius),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .excess_distance(excess_distance)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic longint field_of(logic [47:0] r, int k);
        return longint'($signed(r[16*k +: 16]));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic verdict_t overlap_predict(sphere_t s);
        longint d [3];
        longint acc [3];
        longint a [3];
        longint h, p, ap, hs, e, c;
        longint unsigned sumsq, len;
        bit big;
        verdict_t v;
        d[0] = longint'(s.x) - field_of(box_regs[bsot_pkg::REG_BOX_CENTER], 0);
        d[1] = longint'(s.y) - field_of(box_regs[bsot_pkg::REG_BOX_CENTER], 1);
        d[2] = longint'(s.z) - field_of(box_regs[bsot_pkg::REG_BOX_CENTER], 2);
        acc = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
        begin
            h = field_of(box_regs[bsot_pkg::REG_HALF_EXTENTS], i);
            if (h <= 0)
                continue;
            p = 0;
            for (int k = 0; k < 3; k++)
            begin
                a[k] = field_of(box_regs[bsot_pkg::REG_AXIS_ONE + i], k);
                p += d[k] * a[k];
            end
            ap = (p < 0) ? -p : p;
            hs = h <<< bsot_pkg::AXIS_FRAC;
            if (ap <= hs)
                continue;
            e = (hs - ap + (64'sd1 <<< (bsot_pkg::AXIS_FRAC - 1))) >>> bsot_pkg::AXIS_FRAC;
            for (int k = 0; k < 3; k++)
                acc[k] += e * a[k];
        end
        big = 1'b0;
        sumsq = 0;
        for (int k = 0; k < 3; k++)
        begin
            c = (acc[k] + (64'sd1 <<< (bsot_pkg::AXIS_FRAC - 1))) >>> bsot_pkg::AXIS_FRAC;
            if (c >= 65536 || c <= -65536)
                big = 1'b1;
            sumsq += longint'(c * c);
        end
        if (big)
        begin
            v.hit = 1'b0;
            v.distance = bsot_pkg::OUT_MAX;
            return v;
        end
        len = int_sqrt(sumsq);
        v.hit = (len < s.r);
        v.distance = (len > 65535) ? bsot_pkg::OUT_MAX : len[15:0];
        return v;
    endfunction

    // results: in-order check against the expectation queue
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("box_sphere_overlap_test_tb: done, errors");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            verdict_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result hit=%0b dist=%0d", hit, excess_distance);
            end
            else
            begin
                want = expected_q.pop_front();
                checked++;
                if (hit) hits_seen++;
                if (excess_distance == bsot_pkg::OUT_MAX) sat_seen++;
                if (hit !== want.hit || excess_distance !== want.distance)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result %0d exp hit=%0b dist=%0d got hit=%0b dist=%0d",
                                 checked, want.hit, want.distance, hit, excess_distance);
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_idle);

    // drop valid first so the last transaction is not taken again
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [bsot_pkg::CFG_IDX_WIDTH-1:0] idx,
                             logic [bsot_pkg::REG_WIDTH-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx < NUM_REGS)
            box_regs[idx] = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_box(logic [47:0] c, logic [47:0] h, logic [47:0] a1,
                            logic [47:0] a2, logic [47:0] a3);
        drain();
        write_reg(bsot_pkg::REG_BOX_CENTER, c);
        write_reg(bsot_pkg::REG_HALF_EXTENTS, h);
        write_reg(bsot_pkg::REG_AXIS_ONE, a1);
        write_reg(bsot_pkg::REG_AXIS_TWO, a2);
        write_reg(bsot_pkg::REG_AXIS_THREE, a3);
        write_reg(REG_NONE, bsot_pkg::REG_WIDTH'({$urandom, $urandom}));   // must be ignored
    endtask

    // one sphere transaction; valid stays up between back-to-back items
    task automatic send_sphere(sphere_t s, bit typed, verdict_t fixed);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sphere_x <= s.x;
        sphere_y <= s.y;
        sphere_z <= s.z;
        sphere_radius <= s.r;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(typed ? fixed : overlap_predict(s));
    endtask

    function automatic logic [15:0] rand_half();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'(-$signed(16'($urandom_range(1, 3000))));
            default: return 16'($urandom_range(1, 3000));
        endcase
    endfunction

    function automatic logic [47:0] rand_center();
        return pack3(16'($signed($urandom_range(0, 4000)) - 2000),
                     16'($signed($urandom_range(0, 4000)) - 2000),
                     16'($signed($urandom_range(0, 4000)) - 2000));
    endfunction

    function automatic logic [15:0] rand_unit();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [47:0] rand_reg();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic sphere_t rand_sphere();
        sphere_t s;
        int sel;
        logic [15:0] pick [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            s.x = box_regs[bsot_pkg::REG_BOX_CENTER][15:0]
                  + 16'($signed($urandom_range(0, 16000)) - 8000);
            s.y = box_regs[bsot_pkg::REG_BOX_CENTER][31:16]
                  + 16'($signed($urandom_range(0, 16000)) - 8000);
            s.z = box_regs[bsot_pkg::REG_BOX_CENTER][47:32]
                  + 16'($signed($urandom_range(0, 16000)) - 8000);
        end
        else if (sel < 9)
        begin
            s.x = 16'($urandom);
            s.y = 16'($urandom);
            s.z = 16'($urandom);
        end
        else
        begin
            s.x = pick[$urandom_range(0, 3)];
            s.y = pick[$urandom_range(0, 3)];
            s.z = pick[$urandom_range(0, 3)];
        end
        sel = $urandom_range(0, 9);
        s.r = (sel < 3) ? 15'($urandom) : (sel == 3) ? 15'd0 : 15'($urandom_range(0, 8000));
        return s;
    endfunction

    dir_row_t dir_rows [] = '{
        // reset box: every axis skipped, distance zero
        '{0, '{16'sd0, 16'sd0, 16'sd0, 15'd0}, 1, 1'b0, 16'd0},
        '{0, '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 15'h7FFF}, 1, 1'b1, 16'd0},
        '{0, '{16'sh8000, 16'sh7FFF, 16'sh8000, 15'd1}, 1, 1'b1, 16'd0},
        // unit box at origin
        '{1, '{16'sd0, 16'sd0, 16'sd0, 15'd1}, 1, 1'b1, 16'd0},
        '{1, '{16'sd768, 16'sd0, 16'sd0, 15'd600}, 1, 1'b1, 16'd512},
        '{1, '{16'sd768, 16'sd0, 16'sd0, 15'd513}, 1, 1'b1, 16'd512},
        '{1, '{16'sd768, 16'sd0, 16'sd0, 15'd512}, 1, 1'b0, 16'd512},
        '{1, '{16'sd256, -16'sd256, 16'sd256, 15'd0}, 1, 1'b0, 16'd0},
        '{1, '{16'sd0, -16'sd768, 16'sd0, 15'd300}, 0, 1'b0, 16'd0},
        '{1, '{16'sd512, 16'sd512, 16'sd512, 15'd900}, 0, 1'b0, 16'd0},
        '{1, '{16'sh8000, 16'sh7FFF, 16'sd0, 15'd100}, 0, 1'b0, 16'd0},
        // zero and negative half size, zero axis
        '{2, '{16'sd768, 16'sd768, 16'sd768, 15'd100}, 0, 1'b0, 16'd0},
        '{2, '{16'sd0, 16'sd0, -16'sd1000, 15'd5}, 0, 1'b0, 16'd0},
        '{2, '{16'sd300, 16'sd0, 16'sd0, 15'd50}, 0, 1'b0, 16'd0},
        // oversized component
        '{3, '{16'sh8000, 16'sh8000, 16'sh8000, 15'h7FFF}, 1, 1'b0, 16'hFFFF},
        '{3, '{16'sh7FFF, 16'sd0, 16'sd0, 15'd7}, 0, 1'b0, 16'd0},
        // length past full scale
        '{4, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'h7FFF}, 1, 1'b0, 16'hFFFF},
        '{4, '{16'sh7FFF, 16'sh8000, 16'sd0, 15'd1}, 0, 1'b0, 16'd0}
    };

    initial
    begin
        logic [47:0] ident_a1, ident_a2, ident_a3, c, h, a1, a2, a3;
        int cur_box;
        verdict_t fixed;
        for (int i = 0; i < NUM_REGS; i++)
            box_regs[i] = '0;
        ident_a1 = pack3(Q_ONE, 16'd0, 16'd0);
        ident_a2 = pack3(16'd0, Q_ONE, 16'd0);
        ident_a3 = pack3(16'd0, 16'd0, Q_ONE);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        cur_box = 0;
        foreach (dir_rows[n])
        begin
            if (dir_rows[n].box != cur_box)
            begin
                cur_box = dir_rows[n].box;
                case (cur_box)
                    1: load_box('0, pack3(16'd256, 16'd256, 16'd256),
                                ident_a1, ident_a2, ident_a3);
                    2: load_box('0, pack3(16'd256, 16'd0, 16'hFF00),
                                ident_a1, ident_a2, '0);
                    3: load_box('0, pack3(16'd1, 16'd1, 16'd1), {3{16'h8000}},
                                {3{16'h8000}}, {3{16'h8000}});
                    default: load_box({3{16'h8000}}, pack3(16'd1, 16'd1, 16'd1),
                                      ident_a1, ident_a2, ident_a3);
                endcase
            end
            fixed.hit = dir_rows[n].ehit;
            fixed.distance = dir_rows[n].edist;
            send_sphere(dir_rows[n].s, dir_rows[n].typed, fixed);
        end

        for (int set = 0; set < RAND_SETS; set++)
        begin
            case (set)
                0: begin c = rand_center(); h = pack3(rand_half(), rand_half(), rand_half());
                         a1 = ident_a1; a2 = ident_a2; a3 = ident_a3; end
                1: begin c = rand_center(); h = pack3(rand_half(), rand_half(), rand_half());
                         a1 = pack3(Q_RT2, Q_RT2, 16'd0);
                         a2 = pack3(16'(-$signed(Q_RT2)), Q_RT2, 16'd0); a3 = ident_a3; end
                2: begin c = rand_center();
                         h = pack3(16'($urandom_range(1, 3000)), 16'd0, rand_half());
                         a1 = pack3(16'd0, Q_NEG, 16'd0); a2 = pack3(16'd0, 16'd0, Q_ONE);
                         a3 = pack3(Q_NEG, 16'd0, 16'd0); end
                3: begin c = pack3(16'h7FFF, 16'h8000, 16'h7FFF);
                         h = pack3(16'h7FFF, 16'h7FFF, 16'd1);
                         a1 = pack3(16'h7FFF, 16'h8000, 16'h7FFF); a2 = {3{16'h8000}};
                         a3 = {3{16'h7FFF}}; end
                4: begin c = rand_reg(); h = rand_reg();
                         a1 = rand_reg(); a2 = rand_reg();
                         a3 = rand_reg(); end
                default: begin c = rand_center();
                         h = pack3(rand_half(), rand_half(), rand_half());
                         a1 = pack3(rand_unit(), rand_unit(), rand_unit()); a2 = '0;
                         a3 = pack3(rand_unit(), rand_unit(), rand_unit()); end
            endcase
            load_box(c, h, a1, a2, a3);
            tx_idle = (set < 2) ? 31 : (set < 4) ? 68 : 0;
            rx_idle = (set < 2) ? 68 : (set < 4) ? 31 : 0;
            for (int n = 0; n < SET_ITEMS; n++)
                send_sphere(rand_sphere(), 1'b0, fixed);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Covered %0d results over %0d box settings: %0d hits, %0d saturated.",
                 checked, RAND_SETS + 5, hits_seen, sat_seen);
        $display("Mismatches: %0d", errors);
        if (errors == 0)
            $display("box_sphere_overlap_test_tb: done, clean");
        else
            $display("box_sphere_overlap_test_tb: done, errors");
        $finish;
    end

endmodule
